// ===== sv/nclc_pkg.sv =====
// Package for the nearest colour line locator.
// Types, opcode and colour codes, reset targets. No dependencies.
package nclc_pkg;
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [1:0] COL_RED    = 2'd0;
    localparam logic [1:0] COL_BLUE   = 2'd1;
    localparam logic [1:0] COL_YELLOW = 2'd2;
    localparam logic [1:0] COL_WHITE  = 2'd3;

    localparam int unsigned SUM_MAX   = 255;
    localparam int unsigned COUNT_MAX = 31;

    typedef struct packed {
        logic        operation;
        logic [3:0]  sensor_index;
        logic [1:0]  target_colour;
        logic [11:0] red_level;
        logic [11:0] green_level;
        logic [11:0] blue_level;
        logic        last_sensor;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] colour_class;
        logic       frame_end;
        logic       line_found;
        logic [4:0] line_position;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQR,
        S_ROOT,
        S_DIV,
        S_OUT
    } t_back_state;

    // Reset target, channel 0 red, 1 green, 2 blue.
    function automatic logic [11:0] default_target(input logic [1:0] colour,
                                                   input logic [1:0] chan);
        logic [11:0] v;
        v = 12'd0;
        case ({colour, chan})
            4'b0000: v = 12'd1446;
            4'b0001: v = 12'd1152;
            4'b0010: v = 12'd1368;
            4'b0100: v = 12'd700;
            4'b0101: v = 12'd973;
            4'b0110: v = 12'd1200;
            4'b1000: v = 12'd1407;
            4'b1001: v = 12'd1806;
            4'b1010: v = 12'd881;
            4'b1100: v = 12'd1200;
            4'b1101: v = 12'd1200;
            4'b1110: v = 12'd1200;
            default: v = 12'd0;
        endcase
        return v;
    endfunction
endpackage

// ===== sv/nclc_if.sv =====
// Valid/ready channel interfaces for the colour locator.
// Depends on nclc_pkg.
interface nclc_in_if;
    logic              valid;
    logic              ready;
    nclc_pkg::t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nclc_out_if;
    logic               valid;
    logic               ready;
    nclc_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/nclc_fifo.sv =====
// Two-entry beat queue between front and back parts.
// Depends on nclc_pkg.
module nclc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nclc_pkg::t_in_beat i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output nclc_pkg::t_in_beat o_data
);
    nclc_pkg::t_in_beat r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== sv/nclc_front.sv =====
// Front part: takes input beats, saturates the index, drops bad loads.
// Depends on nclc_pkg and nclc_if.
module nclc_front #(
    parameter int SENSOR_COUNT = 16
) (
    nclc_in_if.sink            in_ch,
    input  logic               i_full,
    output logic               o_push,
    output nclc_pkg::t_in_beat o_data
);
    localparam logic [4:0] SMAX = 5'(SENSOR_COUNT - 1);
    logic in_range;

    assign in_ch.ready = ~i_full;
    assign in_range    = ({1'b0, in_ch.payload.sensor_index} <= SMAX);

    always_comb begin
        o_data = in_ch.payload;
        if (!in_range) begin
            o_data.sensor_index = SMAX[3:0];
        end
        o_push = in_ch.valid & ~i_full &
                 (in_range | (in_ch.payload.operation == nclc_pkg::OP_CLASSIFY));
    end
endmodule

// ===== sv/nclc_back.sv =====
// Back part: target table, distances by iterative square root, line mean.
// Depends on nclc_pkg and nclc_if.
module nclc_back #(
    parameter int SENSOR_COUNT = 16,
    parameter int LEVEL_BITS   = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  nclc_pkg::t_in_beat i_data,
    output logic               o_pop,
    nclc_out_if.source         out_ch
);
    localparam int RB = $clog2(SENSOR_COUNT * 4);
    localparam int SB = 2 * LEVEL_BITS + 2;
    localparam int HB = LEVEL_BITS + 1;
    localparam int KB = $clog2(HB);

    logic [3*LEVEL_BITS-1:0] r_tab [SENSOR_COUNT*4];
    logic [SENSOR_COUNT*4-1:0] r_vld;
    logic [3*LEVEL_BITS-1:0] r_ent;
    logic                    r_ent_v;

    nclc_pkg::t_back_state r_st, n_st;
    logic [1:0]      r_col, n_col;
    logic [1:0]      r_best, n_best;
    logic [HB-1:0]   r_bestd, n_bestd;
    logic [SB-1:0]   r_rem, n_rem;
    logic [HB-1:0]   r_root, n_root;
    logic [KB-1:0]   r_k, n_k;
    logic [7:0]      r_sum, n_sum;
    logic [4:0]      r_cnt, n_cnt;
    logic [7:0]      r_num, n_num;
    logic [4:0]      r_q, n_q;
    logic [2:0]      r_qk, n_qk;
    logic            r_ovld, n_ovld;
    nclc_pkg::t_out_beat r_out, n_out;

    logic [RB-1:0]         rd_addr;
    logic [LEVEL_BITS-1:0] cr, cg, cb, tr, tg, tb;
    logic [LEVEL_BITS-1:0] dr, dg, db;
    logic [SB-1:0]         sq;
    logic [SB-1:0]         trial;
    logic [HB:0]           rt1;
    logic [9:0]            dsub;
    logic [8:0]            nsum;
    logic                  load_wr;

    assign cr = LEVEL_BITS'(i_data.red_level);
    assign cg = LEVEL_BITS'(i_data.green_level);
    assign cb = LEVEL_BITS'(i_data.blue_level);
    assign rd_addr = RB'({i_data.sensor_index, r_col});
    assign load_wr = (r_st == nclc_pkg::S_IDLE) & ~i_empty &
                     (i_data.operation == nclc_pkg::OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_tab[RB'({i_data.sensor_index, i_data.target_colour})] <= {cr, cg, cb};
        end
        r_ent   <= r_tab[rd_addr];
        r_ent_v <= r_vld[rd_addr];
    end

    always_comb begin
        tr = r_ent_v ? r_ent[3*LEVEL_BITS-1:2*LEVEL_BITS]
                     : LEVEL_BITS'(nclc_pkg::default_target(r_col, 2'd0));
        tg = r_ent_v ? r_ent[2*LEVEL_BITS-1:LEVEL_BITS]
                     : LEVEL_BITS'(nclc_pkg::default_target(r_col, 2'd1));
        tb = r_ent_v ? r_ent[LEVEL_BITS-1:0]
                     : LEVEL_BITS'(nclc_pkg::default_target(r_col, 2'd2));
        dr = (cr >= tr) ? cr - tr : tr - cr;
        dg = (cg >= tg) ? cg - tg : tg - cg;
        db = (cb >= tb) ? cb - tb : tb - cb;
        sq = (SB'(dr) * SB'(dr)) + (SB'(dg) * SB'(dg)) + (SB'(db) * SB'(db));
    end

    always_comb begin
        n_st    = r_st;
        n_col   = r_col;
        n_best  = r_best;
        n_bestd = r_bestd;
        n_rem   = r_rem;
        n_root  = r_root;
        n_k     = r_k;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_q     = r_q;
        n_qk    = r_qk;
        n_ovld  = r_ovld;
        n_out   = r_out;
        o_pop   = 1'b0;
        trial   = '0;
        rt1     = '0;
        dsub    = '0;
        nsum    = '0;
        if (out_ch.ready) begin
            n_ovld = 1'b0;
        end
        case (r_st)
            nclc_pkg::S_IDLE: begin
                n_col = 2'd0;
                if (!i_empty) begin
                    if (i_data.operation == nclc_pkg::OP_LOAD) begin
                        o_pop = 1'b1;
                    end else begin
                        n_st = nclc_pkg::S_READ;
                    end
                end
            end
            nclc_pkg::S_READ: begin
                n_st = nclc_pkg::S_SQR;
            end
            nclc_pkg::S_SQR: begin
                n_rem  = sq;
                n_root = '0;
                n_k    = KB'(HB - 1);
                n_st   = nclc_pkg::S_ROOT;
            end
            nclc_pkg::S_ROOT: begin
                // one result bit per cycle, restoring method
                trial = SB'({r_root, 2'b01}) << (2 * r_k);
                rt1   = {r_root, 1'b0};
                if (r_rem >= trial) begin
                    n_rem  = r_rem - trial;
                    rt1[0] = 1'b1;
                end
                n_root = rt1[HB-1:0];
                n_k    = r_k - 1'b1;
                if (r_k == '0) begin
                    if (r_col == 2'd0 || rt1[HB-1:0] < r_bestd) begin
                        n_bestd = rt1[HB-1:0];
                        n_best  = r_col;
                    end
                    if (r_col == 2'd3) begin
                        n_st = nclc_pkg::S_DIV;
                        if ((r_col == 2'd0 || rt1[HB-1:0] < r_bestd) ||
                            r_best == nclc_pkg::COL_WHITE) begin
                            nsum  = {1'b0, r_sum} + {4'd0, i_data.sensor_index, 1'b0};
                            n_sum = nsum[8] ? 8'(nclc_pkg::SUM_MAX) : nsum[7:0];
                            if (r_cnt != 5'(nclc_pkg::COUNT_MAX)) begin
                                n_cnt = r_cnt + 5'd1;
                            end
                        end
                        n_num = n_sum;
                        n_q   = '0;
                        n_qk  = 3'd4;
                    end else begin
                        n_col = r_col + 2'd1;
                        n_st  = nclc_pkg::S_READ;
                    end
                end
            end
            nclc_pkg::S_DIV: begin
                // restoring divide, quotient fits five bits
                dsub = {2'b0, r_num} - ({5'd0, r_cnt} << r_qk);
                rt1  = '0;
                if (!dsub[9] && r_cnt != '0) begin
                    n_num = dsub[7:0];
                    n_q   = r_q | (5'd1 << r_qk);
                end
                n_qk = r_qk - 3'd1;
                if (r_qk == 3'd0 || !i_data.last_sensor) begin
                    n_st = nclc_pkg::S_OUT;
                end
            end
            nclc_pkg::S_OUT: begin
                if (!r_ovld || out_ch.ready) begin
                    n_ovld = 1'b1;
                    n_out.colour_class = r_best;
                    n_out.frame_end    = i_data.last_sensor;
                    n_out.line_found   = i_data.last_sensor & (r_cnt != '0);
                    n_out.line_position = n_out.line_found ? r_q : 5'd0;
                    if (i_data.last_sensor) begin
                        n_sum = '0;
                        n_cnt = '0;
                    end
                    o_pop = 1'b1;
                    n_st  = nclc_pkg::S_IDLE;
                end
            end
            default: n_st = nclc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= nclc_pkg::S_IDLE;
            r_vld  <= '0;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_ovld <= n_ovld;
            if (load_wr) begin
                r_vld[RB'({i_data.sensor_index, i_data.target_colour})] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_best  <= n_best;
        r_bestd <= n_bestd;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_k     <= n_k;
        r_num   <= n_num;
        r_q     <= n_q;
        r_qk    <= n_qk;
        r_out   <= n_out;
    end

    assign out_ch.valid   = r_ovld;
    assign out_ch.payload = r_out;
endmodule

// ===== sv/nearest_colour_line_locator.sv =====
// Top level of the nearest colour line locator.
// Depends on nclc_pkg, nclc_if, nclc_front, nclc_fifo, nclc_back.
//
// Usage:
//   in_ch carries load and classify beats; out_ch carries one result beat
//   per classify beat and none per load beat.
//   A load beat retires in the idle state of the back part. A classify beat
//   passes through table read and square root work for the four targets in
//   turn (one root bit per cycle, one shared root unit), then line mean
//   division, cut short unless the beat is a frame's last, and finally the
//   output state that presents the result beat.
//   A two-beat queue lets the front keep accepting while the back works.
//   Synchronous active-low reset restores the default targets of every
//   sensor (per-entry valid bits), clears the line sum and count, and
//   empties the queue and output register.
//   When the receiver stalls the result register holds and the back part
//   waits; the queue then fills and in_ch.ready drops.
module nearest_colour_line_locator #(
    parameter int SENSOR_COUNT = 16,
    parameter int LEVEL_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nclc_in_if.sink     in_ch,
    nclc_out_if.source  out_ch
);
    logic               push, full, pop, empty;
    nclc_pkg::t_in_beat fdata, qdata;

    nclc_front #(.SENSOR_COUNT(SENSOR_COUNT)) u_front (
        .in_ch  (in_ch),
        .i_full (full),
        .o_push (push),
        .o_data (fdata)
    );

    nclc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fdata),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (qdata)
    );

    nclc_back #(.SENSOR_COUNT(SENSOR_COUNT), .LEVEL_BITS(LEVEL_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_data  (qdata),
        .o_pop   (pop),
        .out_ch  (out_ch)
    );

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_pos_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.payload.line_found |-> out_ch.payload.line_position == 5'd0)
        else $error("position without line");
    a_found_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.payload.line_found |-> out_ch.payload.frame_end)
        else $error("line found outside frame end");
`endif
endmodule

// ===== sim/tb.sv =====
// Testbench for nearest_colour_line_locator: random load/classify beats
// checked against a behavioral nearest-target predictor. Depends on nclc_pkg, nclc_if.
`timescale 1ns / 100ps

class colour_scoreboard;
    logic [11:0] targets [16][4][3];
    int unsigned white_sum;
    int unsigned white_cnt;
    nclc_pkg::t_out_beat pending[$];
    int errors;
    int results_seen;
    int frames_seen;
    int lines_seen;

    function new();
        errors = 0;
        results_seen = 0;
        frames_seen = 0;
        lines_seen = 0;
        white_sum = 0;
        white_cnt = 0;
        for (int s = 0; s < 16; s++)
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 3; k++)
                    targets[s][c][k] = nclc_pkg::default_target(c[1:0], k[1:0]);
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                r = r | (64'd1 << b);
        return r;
    endfunction

    function void note_beat(nclc_pkg::t_in_beat b);
        nclc_pkg::t_out_beat o;
        int unsigned idx, d, best_d;
        logic [1:0] best;
        longint unsigned acc, df;
        idx = b.sensor_index;
        if (b.operation == nclc_pkg::OP_LOAD) begin
            if (idx < 16) begin
                targets[idx][b.target_colour][0] = b.red_level;
                targets[idx][b.target_colour][1] = b.green_level;
                targets[idx][b.target_colour][2] = b.blue_level;
            end
            return;
        end
        best = nclc_pkg::COL_RED;
        best_d = 0;
        for (int c = 0; c < 4; c++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                df = (k == 0) ? b.red_level : (k == 1) ? b.green_level : b.blue_level;
                df = (df >= targets[idx][c][k]) ? df - targets[idx][c][k]
                                                : targets[idx][c][k] - df;
                acc += df * df;
            end
            d = root_floor(acc);
            if (c == 0 || d < best_d) begin
                best_d = d;
                best = c[1:0];
            end
        end
        if (best == nclc_pkg::COL_WHITE) begin
            white_sum += 2 * idx;
            if (white_sum > nclc_pkg::SUM_MAX) white_sum = nclc_pkg::SUM_MAX;
            if (white_cnt < nclc_pkg::COUNT_MAX) white_cnt++;
        end
        o = '0;
        o.colour_class = best;
        o.frame_end = b.last_sensor;
        if (b.last_sensor) begin
            if (white_cnt != 0) begin
                o.line_found = 1'b1;
                o.line_position = 5'((white_sum / white_cnt) & 31);
            end
            white_sum = 0;
            white_cnt = 0;
        end
        pending.push_back(o);
    endfunction

    function void check_result(nclc_pkg::t_out_beat a);
        nclc_pkg::t_out_beat e;
        results_seen++;
        if (pending.size() == 0) begin
            $error("unexpected result beat %p", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.frame_end) frames_seen++;
        if (a.line_found) lines_seen++;
        if (a.colour_class !== e.colour_class) begin
            $error("colour_class exp %0d got %0d", e.colour_class, a.colour_class);
            errors++;
        end
        if (a.frame_end !== e.frame_end) begin
            $error("frame_end exp %0d got %0d", e.frame_end, a.frame_end);
            errors++;
        end
        if (a.line_found !== e.line_found) begin
            $error("line_found exp %0d got %0d", e.line_found, a.line_found);
            errors++;
        end
        if (a.line_position !== e.line_position) begin
            $error("line_position exp %0d got %0d", e.line_position, a.line_position);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    nclc_in_if  in_ch();
    nclc_out_if out_ch();

    colour_scoreboard sb;
    int idle_cycles;
    int beats_sent;
    bit stall_heavy;

    nearest_colour_line_locator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_beat(in_ch.payload);
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver stalls: phases of heavy or light backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else begin
            if ($urandom_range(0, 199) == 0) stall_heavy = !stall_heavy;
            out_ch.ready <= stall_heavy ? ($urandom_range(0, 3) == 0)
                                        : ($urandom_range(0, 7) != 0);
        end
    end

    function automatic nclc_pkg::t_in_beat rand_level_beat(logic op, logic [3:0] idx);
        nclc_pkg::t_in_beat b;
        b.operation     = op;
        b.sensor_index  = idx;
        b.target_colour = 2'($urandom_range(0, 3));
        b.red_level     = 12'($urandom);
        b.green_level   = 12'($urandom);
        b.blue_level    = 12'($urandom);
        b.last_sensor   = 1'($urandom);
        return b;
    endfunction

    // near a target with small noise, so white is hit often
    function automatic nclc_pkg::t_in_beat near_beat(logic [3:0] idx, logic last);
        nclc_pkg::t_in_beat b;
        logic [1:0] c;
        c = 2'($urandom_range(0, 3));
        b = '0;
        b.operation    = nclc_pkg::OP_CLASSIFY;
        b.sensor_index = idx;
        b.last_sensor  = last;
        b.red_level    = 12'(sb.targets[idx][c][0] + $urandom_range(0, 40) - 20);
        b.green_level  = 12'(sb.targets[idx][c][1] + $urandom_range(0, 40) - 20);
        b.blue_level   = 12'(sb.targets[idx][c][2] + $urandom_range(0, 40) - 20);
        return b;
    endfunction

    task automatic send_beat(nclc_pkg::t_in_beat b);
        in_ch.payload <= b;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        beats_sent++;
        if ($urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic send_frame(int len, bit all_white);
        nclc_pkg::t_in_beat b;
        for (int k = 0; k < len; k++) begin
            if (all_white) begin
                b = '0;
                b.operation = nclc_pkg::OP_CLASSIFY;
                b.sensor_index = 4'(k);
                b.red_level = 12'd1200;
                b.green_level = 12'd1200;
                b.blue_level = 12'd1200;
                b.last_sensor = (k == len - 1);
            end else
                b = near_beat(4'($urandom_range(0, 15)), k == len - 1);
            send_beat(b);
        end
    endtask

    initial begin
        nclc_pkg::t_in_beat b;
        sb = new();
        beats_sent = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset targets exactly, in order, then a tie between red and blue
        for (int c = 0; c < 4; c++) begin
            b = '0;
            b.operation = nclc_pkg::OP_CLASSIFY;
            b.sensor_index = 4'd3;
            b.red_level = nclc_pkg::default_target(c[1:0], 2'd0);
            b.green_level = nclc_pkg::default_target(c[1:0], 2'd1);
            b.blue_level = nclc_pkg::default_target(c[1:0], 2'd2);
            send_beat(b);
        end
        b = '0;
        b.operation = nclc_pkg::OP_LOAD;
        b.sensor_index = 4'd5;
        b.target_colour = nclc_pkg::COL_BLUE;
        b.red_level = 12'd1446;
        b.green_level = 12'd1152;
        b.blue_level = 12'd1368;
        send_beat(b);
        b.operation = nclc_pkg::OP_CLASSIFY;
        b.last_sensor = 1'b1;
        send_beat(b);
        // extremes of the levels
        b = '0;
        b.operation = nclc_pkg::OP_CLASSIFY;
        b.sensor_index = 4'd15;
        send_beat(b);
        b.red_level = 12'hfff;
        b.green_level = 12'hfff;
        b.blue_level = 12'hfff;
        b.last_sensor = 1'b1;
        send_beat(b);
        // load the all-ones levels as the white target, then classify against it
        b.operation = nclc_pkg::OP_LOAD;
        b.target_colour = nclc_pkg::COL_WHITE;
        b.sensor_index = 4'd0;
        send_beat(b);
        b.operation = nclc_pkg::OP_CLASSIFY;
        b.last_sensor = 1'b0;
        send_beat(b);
        // all sixteen white: line mean over a full frame
        send_frame(16, 1'b1);

        while (beats_sent < 1000) begin
            case ($urandom_range(0, 9))
                0, 1: send_beat(rand_level_beat(nclc_pkg::OP_LOAD, 4'($urandom)));
                2: send_beat(rand_level_beat(nclc_pkg::OP_CLASSIFY, 4'($urandom)));
                3: send_frame(16, 1'b1);
                default: send_frame($urandom_range(1, 16), 1'b0);
            endcase
        end
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("beats sent %0d, results checked %0d, frames %0d, frames with a line %0d",
                 beats_sent, sb.results_seen, sb.frames_seen, sb.lines_seen);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
sv/nclc_pkg.sv
sv/nclc_if.sv
sv/nclc_fifo.sv
sv/nclc_front.sv
sv/nclc_back.sv
sv/nearest_colour_line_locator.sv
sim/tb.sv
